>>> rtl/ptx_pkg.sv
// Shared constants and item types for the permutation crossover block.
package ptx_pkg;

    localparam int MAX_GENES = 64;
    localparam int GENE_BITS = 8;
    localparam int IDX_W     = $clog2(MAX_GENES);
    localparam int LEN_W     = IDX_W + 1;
    localparam int RAW_W     = 2 * IDX_W + 1;
    localparam int CFG_W     = 7;

    localparam logic       OP_LOAD  = 1'b0;
    localparam logic       OP_CROSS = 1'b1;
    localparam logic       ST_CHILD = 1'b0;
    localparam logic       ST_RETRY = 1'b1;
    localparam logic       REG_GENOME_LENGTH = 1'b0;
    localparam logic       REG_MIN_SPAN      = 1'b1;

    typedef struct packed {
        logic                 op;
        logic [IDX_W-1:0]     gene_index;
        logic [GENE_BITS-1:0] gene_a;
        logic [GENE_BITS-1:0] gene_b;
        logic [IDX_W-1:0]     draw_one;
        logic [IDX_W-1:0]     draw_two;
    } in_item_t;

    typedef struct packed {
        logic                 status;
        logic [IDX_W-1:0]     out_index;
        logic [GENE_BITS-1:0] child_a;
        logic [GENE_BITS-1:0] child_b;
        logic                 repair_mismatch;
        logic                 last;
    } out_item_t;

endpackage

>>> rtl/ptx_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ptx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/permutation_two_point_crossover_unit.sv
// Top level of the permutation two-point crossover unit with repair.
//
// Input channel s_valid/s_ready/s_item carries two kinds of item. A load item
// writes one gene pair of the two parents and gives no result. A cross item
// brings two cut draws. A bad draw or a too-short span gives a single retry
// item on the result channel. Otherwise the unit copies both parents into the
// child memories with the segment exchanged, scans the segment against the
// rest for duplicates, swaps hole pairs and emits the children, one item at a
// time, index 0 first, last set on the final one. One cross is handled at a
// time; s_ready is high only while the unit is idle.
// The result channel m_valid/m_ready/m_item has one output register; while the
// receiver stalls the emit sequence holds and nothing is lost.
// Reset (aresetn, synchronous, active low) returns to idle, empties the output
// register and restores genome_length 64 and min_span 3. Parent genes are not
// cleared: load every gene in use before a cross.
module permutation_two_point_crossover_unit
    import ptx_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wen,
    input  logic             cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_item,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_item
);
    typedef enum logic [3:0] {
        S_IDLE, S_RETRY, S_CP_RD, S_CP_WR, S_SC_RI, S_SC_LI, S_SC_RJ, S_SC_CJ,
        S_SC_END, S_SW_RH, S_SW_RC, S_SW_WR, S_EM_RD, S_EM_OUT
    } state_t;

    state_t                state_reg;
    logic [LEN_W-1:0]      glen_reg;
    logic [IDX_W-1:0]      min_span_reg;
    logic [IDX_W-1:0]      lo_reg, hi_reg;
    logic [LEN_W-1:0]      len_reg, i_reg, j_reg, k_reg;
    logic [LEN_W-1:0]      cnt_a_reg, cnt_b_reg;
    logic [RAW_W-1:0]      raw_a_reg, raw_b_reg;
    logic [GENE_BITS-1:0]  vi_a_reg, vi_b_reg;
    logic                  m_valid_reg;
    out_item_t             m_item_reg;

    // parent memory holds {a, b}
    logic                      par_we;
    logic [IDX_W-1:0]          par_raddr;
    logic [2*GENE_BITS-1:0]    par_rdata;
    logic [GENE_BITS-1:0]      pa_rd, pb_rd;
    logic                      ch_we;
    logic [IDX_W-1:0]          cha_waddr, chb_waddr, cha_raddr, chb_raddr;
    logic [GENE_BITS-1:0]      cha_wdata, chb_wdata, cha_rd, chb_rd;
    logic                      hla_we, hlb_we;
    logic [IDX_W-1:0]          hla_rd, hlb_rd;

    logic                  accept, out_free;
    logic [LEN_W-1:0]      len_c, lo_c, hi_c;
    logic [IDX_W-1:0]      dmin, dmax;
    logic                  bad_draw, short_span;
    logic                  seg_i, seg_j, hit_a, hit_b;
    logic [LEN_W-1:0]      npair;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign pa_rd    = par_rdata[2*GENE_BITS-1:GENE_BITS];
    assign pb_rd    = par_rdata[GENE_BITS-1:0];

    // cut decode for the incoming cross item
    always_comb begin
        if (glen_reg < LEN_W'(2)) begin
            len_c = LEN_W'(2);
        end else if (glen_reg > LEN_W'(MAX_GENES)) begin
            len_c = LEN_W'(MAX_GENES);
        end else begin
            len_c = glen_reg;
        end
        dmin = (s_item.draw_one < s_item.draw_two) ? s_item.draw_one : s_item.draw_two;
        dmax = (s_item.draw_one < s_item.draw_two) ? s_item.draw_two : s_item.draw_one;
        lo_c = (dmin == '0) ? LEN_W'(1) : {1'b0, dmin};
        hi_c = {1'b0, dmax};
        bad_draw   = ({1'b0, s_item.draw_one} >= len_c) || ({1'b0, s_item.draw_two} >= len_c);
        short_span = (hi_c < lo_c + {1'b0, min_span_reg})
                     && (len_c > {1'b0, min_span_reg} + LEN_W'(1));
    end

    assign seg_i = (i_reg >= {1'b0, lo_reg}) && (i_reg < {1'b0, hi_reg});
    assign seg_j = (j_reg >= {1'b0, lo_reg}) && (j_reg < {1'b0, hi_reg});
    assign hit_a = (state_reg == S_SC_CJ) && !seg_j && (pa_rd == vi_a_reg);
    assign hit_b = (state_reg == S_SC_CJ) && !seg_j && (pb_rd == vi_b_reg);
    assign npair = (cnt_a_reg < cnt_b_reg) ? cnt_a_reg : cnt_b_reg;

    // memory port steering
    always_comb begin
        par_we    = accept && (s_item.op == OP_LOAD);
        par_raddr = (state_reg == S_SC_RJ || state_reg == S_SC_CJ) ? j_reg[IDX_W-1:0]
                                                                   : i_reg[IDX_W-1:0];
        ch_we     = (state_reg == S_CP_WR) || (state_reg == S_SW_WR);
        if (state_reg == S_CP_WR) begin
            cha_waddr = i_reg[IDX_W-1:0];
            chb_waddr = i_reg[IDX_W-1:0];
            cha_wdata = seg_i ? pb_rd : pa_rd;
            chb_wdata = seg_i ? pa_rd : pb_rd;
        end else begin
            cha_waddr = hla_rd;
            chb_waddr = hlb_rd;
            cha_wdata = chb_rd;
            chb_wdata = cha_rd;
        end
        if (state_reg == S_SW_RC || state_reg == S_SW_WR) begin
            cha_raddr = hla_rd;
            chb_raddr = hlb_rd;
        end else begin
            cha_raddr = k_reg[IDX_W-1:0];
            chb_raddr = k_reg[IDX_W-1:0];
        end
        hla_we = hit_a && (cnt_a_reg < LEN_W'(MAX_GENES));
        hlb_we = hit_b && (cnt_b_reg < LEN_W'(MAX_GENES));
    end

    ptx_ram #(.WIDTH(2*GENE_BITS), .DEPTH(MAX_GENES)) u_par (
        .aclk(aclk), .we(par_we), .waddr(s_item.gene_index),
        .wdata({s_item.gene_a, s_item.gene_b}), .raddr(par_raddr), .rdata(par_rdata)
    );
    ptx_ram #(.WIDTH(GENE_BITS), .DEPTH(MAX_GENES)) u_cha (
        .aclk(aclk), .we(ch_we), .waddr(cha_waddr), .wdata(cha_wdata),
        .raddr(cha_raddr), .rdata(cha_rd)
    );
    ptx_ram #(.WIDTH(GENE_BITS), .DEPTH(MAX_GENES)) u_chb (
        .aclk(aclk), .we(ch_we), .waddr(chb_waddr), .wdata(chb_wdata),
        .raddr(chb_raddr), .rdata(chb_rd)
    );
    ptx_ram #(.WIDTH(IDX_W), .DEPTH(MAX_GENES)) u_hla (
        .aclk(aclk), .we(hla_we), .waddr(cnt_a_reg[IDX_W-1:0]), .wdata(j_reg[IDX_W-1:0]),
        .raddr(k_reg[IDX_W-1:0]), .rdata(hla_rd)
    );
    ptx_ram #(.WIDTH(IDX_W), .DEPTH(MAX_GENES)) u_hlb (
        .aclk(aclk), .we(hlb_we), .waddr(cnt_b_reg[IDX_W-1:0]), .wdata(j_reg[IDX_W-1:0]),
        .raddr(k_reg[IDX_W-1:0]), .rdata(hlb_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            glen_reg     <= LEN_W'(MAX_GENES);
            min_span_reg <= IDX_W'(3);
            m_valid_reg  <= 1'b0;
            cnt_a_reg    <= '0;
            cnt_b_reg    <= '0;
            raw_a_reg    <= '0;
            raw_b_reg    <= '0;
        end else begin
            if (cfg_wen) begin
                unique case (cfg_addr)
                    REG_GENOME_LENGTH: glen_reg     <= cfg_wdata[LEN_W-1:0];
                    REG_MIN_SPAN:      min_span_reg <= cfg_wdata[IDX_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (hla_we) cnt_a_reg <= cnt_a_reg + LEN_W'(1);
            if (hlb_we) cnt_b_reg <= cnt_b_reg + LEN_W'(1);
            if (hit_a)  raw_a_reg <= raw_a_reg + RAW_W'(1);
            if (hit_b)  raw_b_reg <= raw_b_reg + RAW_W'(1);

            unique case (state_reg)
                S_IDLE: begin
                    if (accept && s_item.op == OP_CROSS) begin
                        if (bad_draw || short_span) begin
                            state_reg <= S_RETRY;
                        end else begin
                            lo_reg    <= lo_c[IDX_W-1:0];
                            hi_reg    <= dmax;
                            len_reg   <= len_c;
                            i_reg     <= '0;
                            cnt_a_reg <= '0;
                            cnt_b_reg <= '0;
                            raw_a_reg <= '0;
                            raw_b_reg <= '0;
                            state_reg <= S_CP_RD;
                        end
                    end
                end
                S_RETRY: begin
                    if (out_free) begin
                        m_valid_reg                <= 1'b1;
                        m_item_reg                 <= '0;
                        m_item_reg.status          <= ST_RETRY;
                        m_item_reg.last            <= 1'b1;
                        state_reg                  <= S_IDLE;
                    end
                end
                S_CP_RD: state_reg <= S_CP_WR;
                S_CP_WR: begin
                    if (i_reg == len_reg - LEN_W'(1)) begin
                        i_reg <= {1'b0, lo_reg};
                        k_reg <= '0;
                        state_reg <= (lo_reg < hi_reg) ? S_SC_RI : S_EM_RD;
                    end else begin
                        i_reg     <= i_reg + LEN_W'(1);
                        state_reg <= S_CP_RD;
                    end
                end
                S_SC_RI: state_reg <= S_SC_LI;
                S_SC_LI: begin
                    // child a holds parent b inside the segment, and the reverse
                    vi_a_reg  <= pb_rd;
                    vi_b_reg  <= pa_rd;
                    j_reg     <= '0;
                    state_reg <= S_SC_RJ;
                end
                S_SC_RJ: state_reg <= S_SC_CJ;
                S_SC_CJ: begin
                    if (j_reg == len_reg - LEN_W'(1)) begin
                        if (i_reg == {1'b0, hi_reg} - LEN_W'(1)) begin
                            state_reg <= S_SC_END;
                        end else begin
                            i_reg     <= i_reg + LEN_W'(1);
                            state_reg <= S_SC_RI;
                        end
                    end else begin
                        j_reg     <= j_reg + LEN_W'(1);
                        state_reg <= S_SC_RJ;
                    end
                end
                S_SC_END: begin
                    k_reg     <= '0;
                    state_reg <= (npair == '0) ? S_EM_RD : S_SW_RH;
                end
                S_SW_RH: state_reg <= S_SW_RC;
                S_SW_RC: state_reg <= S_SW_WR;
                S_SW_WR: begin
                    if (k_reg == npair - LEN_W'(1)) begin
                        k_reg     <= '0;
                        state_reg <= S_EM_RD;
                    end else begin
                        k_reg     <= k_reg + LEN_W'(1);
                        state_reg <= S_SW_RH;
                    end
                end
                S_EM_RD: state_reg <= S_EM_OUT;
                S_EM_OUT: begin
                    // hold the read address until the output register frees
                    if (out_free) begin
                        m_valid_reg                <= 1'b1;
                        m_item_reg.status          <= ST_CHILD;
                        m_item_reg.out_index       <= k_reg[IDX_W-1:0];
                        m_item_reg.child_a         <= cha_rd;
                        m_item_reg.child_b         <= chb_rd;
                        m_item_reg.repair_mismatch <= (raw_a_reg != raw_b_reg);
                        m_item_reg.last            <= (k_reg == len_reg - LEN_W'(1));
                        if (k_reg == len_reg - LEN_W'(1)) begin
                            state_reg <= S_IDLE;
                        end else begin
                            k_reg     <= k_reg + LEN_W'(1);
                            state_reg <= S_EM_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> verif/tb_permutation_two_point_crossover_unit.sv
// Self-checking testbench for the permutation two-point crossover unit.
module tb_permutation_two_point_crossover_unit;
    import ptx_pkg::*;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wen;
    logic             cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;
    logic             s_valid;
    logic             s_ready;
    in_item_t         s_item;
    logic             m_valid;
    logic             m_ready;
    out_item_t        m_item;

    permutation_two_point_crossover_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    localparam int CYCLE_LIMIT = 10000000;

    // predictor state
    logic [GENE_BITS-1:0] par_a [MAX_GENES];
    logic [GENE_BITS-1:0] par_b [MAX_GENES];
    int unsigned          cur_len;
    int unsigned          cur_span;

    out_item_t child_queue[$];
    int        errors;
    int        n_items;
    int        n_children;
    int        n_retries;
    int        n_mismatch;
    longint    cycles;
    bit        calm;

    always begin
        aclk = 1'b1; #2;
        aclk = 1'b0; #2;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_permutation_two_point_crossover_unit failed");
            $finish;
        end
    end

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    function automatic int eff_len();
        if (cur_len < 2) return 2;
        if (cur_len > MAX_GENES) return MAX_GENES;
        return cur_len;
    endfunction

    // work out the children of one cross item
    task automatic predict_cross(input in_item_t it);
        logic [GENE_BITS-1:0] ca [MAX_GENES];
        logic [GENE_BITS-1:0] cb [MAX_GENES];
        int ha[$];
        int hb[$];
        int len, d1, d2, lo, hi, npair, ra, rb;
        logic [GENE_BITS-1:0] t;
        logic mis;
        out_item_t r;
        len = eff_len();
        d1 = it.draw_one;
        d2 = it.draw_two;
        ra = 0;
        rb = 0;
        if (d1 >= len || d2 >= len) begin
            r = '0; r.status = ST_RETRY; r.last = 1'b1;
            child_queue = {child_queue, r};
            n_retries++;
            return;
        end
        lo = d1 < d2 ? d1 : d2;
        hi = d1 < d2 ? d2 : d1;
        if (lo < 1) lo = 1;
        if (hi - lo < int'(cur_span) && len > int'(cur_span) + 1) begin
            r = '0; r.status = ST_RETRY; r.last = 1'b1;
            child_queue = {child_queue, r};
            n_retries++;
            return;
        end
        for (int i = 0; i < len; i++) begin
            ca[i] = par_a[i];
            cb[i] = par_b[i];
        end
        for (int i = lo; i < hi; i++) begin
            ca[i] = par_b[i];
            cb[i] = par_a[i];
        end
        for (int i = lo; i < hi; i++)
            for (int j = 0; j < len; j++) begin
                if (j >= lo && j < hi) continue;
                if (ca[j] == ca[i]) begin
                    ra++;
                    if (ha.size() < MAX_GENES) ha = {ha, j};
                end
                if (cb[j] == cb[i]) begin
                    rb++;
                    if (hb.size() < MAX_GENES) hb = {hb, j};
                end
            end
        mis = (ra != rb);
        if (mis) n_mismatch++;
        npair = ha.size() < hb.size() ? ha.size() : hb.size();
        for (int k = 0; k < npair; k++) begin
            t = ca[ha[k]];
            ca[ha[k]] = cb[hb[k]];
            cb[hb[k]] = t;
        end
        for (int k = 0; k < len; k++) begin
            r.status = ST_CHILD;
            r.out_index = k[IDX_W-1:0];
            r.child_a = ca[k];
            r.child_b = cb[k];
            r.repair_mismatch = mis;
            r.last = (k == len - 1);
            child_queue = {child_queue, r};
        end
        n_children++;
    endtask

    // send one item; predict at acceptance
    // valid stays high into a following item; gaps and drain drop it
    task automatic send_item(input in_item_t it);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_items++;
        if (it.op == OP_LOAD) begin
            par_a[it.gene_index] = it.gene_a;
            par_b[it.gene_index] = it.gene_b;
        end else begin
            predict_cross(it);
        end
    endtask

    task automatic send_load(input int idx, input int a, input int b);
        in_item_t it;
        it = '0;
        it.op = OP_LOAD;
        it.gene_index = idx[IDX_W-1:0];
        it.gene_a = a[GENE_BITS-1:0];
        it.gene_b = b[GENE_BITS-1:0];
        it.draw_one = IDX_W'($urandom);
        it.draw_two = IDX_W'($urandom);
        send_item(it);
    endtask

    task automatic send_cross(input int d1, input int d2);
        in_item_t it;
        it = '0;
        it.op = OP_CROSS;
        it.gene_index = IDX_W'($urandom);
        it.gene_a = GENE_BITS'($urandom);
        it.gene_b = GENE_BITS'($urandom);
        it.draw_one = d1[IDX_W-1:0];
        it.draw_two = d2[IDX_W-1:0];
        send_item(it);
    endtask

    // load two parents; perm selects shuffled permutations, else random genes
    task automatic load_parents(input bit perm);
        int pa[$];
        int pb[$];
        int base;
        base = $urandom_range(0, 255 - 64);
        for (int i = 0; i < eff_len(); i++) begin
            pa = {pa, base + i};
            pb = {pb, base + i};
        end
        pa.shuffle();
        pb.shuffle();
        for (int i = 0; i < eff_len(); i++)
            if (perm) send_load(i, pa[i], pb[i]);
            else send_load(i, $urandom_range(0, 7), $urandom_range(0, 7));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (child_queue.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic addr, input int val);
        drain();
        cfg_wen   <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val[CFG_W-1:0];
        @(posedge aclk);
        cfg_wen <= 1'b0;
        if (addr == REG_GENOME_LENGTH) cur_len = val & 127;
        else cur_span = val & 63;
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (child_queue.size() == 0) begin
                report($sformatf("unexpected item idx %0d", m_item.out_index));
            end else begin
                out_item_t e;
                e = child_queue.pop_front();
                if (m_item.status !== e.status)
                    report($sformatf("status got %0b want %0b", m_item.status, e.status));
                if (m_item.out_index !== e.out_index)
                    report($sformatf("index got %0d want %0d", m_item.out_index, e.out_index));
                if (m_item.child_a !== e.child_a)
                    report($sformatf("child_a[%0d] got %0d want %0d",
                                     e.out_index, m_item.child_a, e.child_a));
                if (m_item.child_b !== e.child_b)
                    report($sformatf("child_b[%0d] got %0d want %0d",
                                     e.out_index, m_item.child_b, e.child_b));
                if (m_item.repair_mismatch !== e.repair_mismatch)
                    report($sformatf("repair_mismatch[%0d] got %0b want %0b",
                                     e.out_index, m_item.repair_mismatch, e.repair_mismatch));
                if (m_item.last !== e.last)
                    report($sformatf("last[%0d] got %0b want %0b",
                                     e.out_index, m_item.last, e.last));
            end
        end
    end

    int stall_left;
    always @(posedge aclk) begin
        if (!aresetn || calm) begin
            m_ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= (stall_left == 1);
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 10);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic test_directed();
        // full length, bounds of draws and span
        load_parents(1'b1);
        send_load(0, 255, 0);
        send_load(0, 0, 255);
        send_cross(63, 0);
        send_cross(0, 0);
        send_cross(10, 11);
        send_cross(1, 63);
        send_cross(40, 20);
    endtask

    task automatic test_short_genomes();
        write_reg(REG_MIN_SPAN, 0);
        write_reg(REG_GENOME_LENGTH, 2);
        load_parents(1'b1);
        send_cross(0, 0);
        send_cross(1, 0);
        send_cross(2, 1);
        write_reg(REG_GENOME_LENGTH, 0);
        send_cross(1, 1);
        write_reg(REG_GENOME_LENGTH, 127);
        send_cross(5, 5);
        write_reg(REG_MIN_SPAN, 63);
        send_cross(62, 1);
        send_cross(63, 0);
        drain();
    endtask

    task automatic test_broken_parents();
        write_reg(REG_GENOME_LENGTH, 12);
        write_reg(REG_MIN_SPAN, 2);
        load_parents(1'b0);
        send_cross(2, 9);
        send_cross(0, 11);
        // all equal genes overflow the hole lists
        write_reg(REG_GENOME_LENGTH, 64);
        write_reg(REG_MIN_SPAN, 0);
        for (int i = 0; i < 64; i++) send_load(i, 7, 7);
        send_cross(1, 63);
        drain();
    endtask

    task automatic test_random(input int budget);
        int used;
        used = 0;
        while (used < budget) begin
            write_reg(REG_GENOME_LENGTH, ($urandom_range(0, 7) == 0) ?
                      $urandom_range(33, 64) : $urandom_range(2, 12));
            write_reg(REG_MIN_SPAN, $urandom_range(0, 5));
            load_parents($urandom_range(0, 3) != 0);
            used += eff_len();
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 5) == 0)
                    send_cross($urandom_range(0, 63), $urandom_range(0, 63));
                else
                    send_cross($urandom_range(0, eff_len() - 1),
                               $urandom_range(0, eff_len() - 1));
                used++;
                if ($urandom_range(0, 4) == 0)
                    send_load($urandom_range(0, eff_len() - 1), $urandom, $urandom);
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wen = 1'b0; cfg_addr = 1'b0; cfg_wdata = '0;
        s_valid = 1'b0; s_item = '0; m_ready = 1'b0;
        errors = 0; n_items = 0; n_children = 0; n_retries = 0; n_mismatch = 0;
        cycles = 0; calm = 1'b0;
        cur_len = 64; cur_span = 3;
        for (int i = 0; i < MAX_GENES; i++) begin
            par_a[i] = '0; par_b[i] = '0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_short_genomes();
        test_broken_parents();
        test_random(60);
        calm = 1'b1;
        test_random(20);
        drain();
        $display("%0d items sent: %0d crosses completed, %0d retries, %0d with hole mismatch",
                 n_items, n_children, n_retries, n_mismatch);
        if (errors == 0)
            $display("tb_permutation_two_point_crossover_unit passed");
        else
            $display("tb_permutation_two_point_crossover_unit failed");
        $finish;
    end

endmodule
